// File: hw/rtl/bsor_pkg.sv
// Shared types and constants for the bitmap shape outline rasterizer.
// Used by bsor_hit and the top level; depends on nothing else.
`default_nettype none

package bsor_pkg;

  localparam int FRAME_ROWS = 20;
  localparam int FRAME_COLS = 40;

  localparam int ROW_AW  = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
  localparam int COL_AW  = (FRAME_COLS > 1) ? $clog2(FRAME_COLS) : 1;
  localparam int OUT_W   = 40;
  localparam int PAD_W   = (FRAME_COLS > OUT_W) ? FRAME_COLS : OUT_W;

  // Signed coordinate width: covers x + width - 1 and negative offsets.
  localparam int COORD_W = 9;
  localparam int MAG_W   = COORD_W - 1;
  localparam int SQ_W    = 2 * MAG_W + 1;
  localparam int RING_W  = 10;

  typedef enum logic [2:0] {
    FN_CLEAR = 3'd0,
    FN_LINE  = 3'd1,
    FN_RECT  = 3'd2,
    FN_TRI   = 3'd3,
    FN_RING  = 3'd4,
    FN_READ  = 3'd5
  } func_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [5:0]        x_start;
    logic [4:0]        y_start;
    logic [5:0]        x_end;
    logic [4:0]        y_end;
    logic [5:0]        width;
    logic [4:0]        height;
    logic [4:0]        radius;
    logic [RING_W-1:0] ring_lo;
    logic [RING_W-1:0] ring_hi;
  } cmd_t;

  function automatic logic [OUT_W-1:0] row_to_out(input logic [FRAME_COLS-1:0] row);
    logic [PAD_W-1:0] padded;
    padded = PAD_W'(row);
    return padded[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bsor_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module bsor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bsor_hit.sv
// Shared pixel test: decides whether the latched shape covers one frame pixel.
// Depends on bsor_pkg for the command struct and coordinate widths.
`default_nettype none

module bsor_hit (
  input  wire bsor_pkg::cmd_t                   cmd,
  input  wire logic [bsor_pkg::COL_AW-1:0]      px,
  input  wire logic [bsor_pkg::ROW_AW-1:0]      py,
  output logic                                  hit
);

  logic signed [bsor_pkg::COORD_W-1:0] sx, sy, xs, ys, xe, ye;
  logic signed [bsor_pkg::COORD_W-1:0] w_s, h_s, x_right, y_bot;
  logic signed [bsor_pkg::COORD_W-1:0] dx, dy, adx, ady;
  logic [2*bsor_pkg::MAG_W-1:0]         sq_x, sq_y;
  logic [bsor_pkg::SQ_W-1:0]            sq_sum;
  logic                                 line_hit, rect_hit, tri_hit, ring_hit;
  logic                                 in_x, in_y;

  always_comb begin
    sx  = signed'(bsor_pkg::COORD_W'(px));
    sy  = signed'(bsor_pkg::COORD_W'(py));
    xs  = signed'(bsor_pkg::COORD_W'(cmd.x_start));
    ys  = signed'(bsor_pkg::COORD_W'(cmd.y_start));
    xe  = signed'(bsor_pkg::COORD_W'(cmd.x_end));
    ye  = signed'(bsor_pkg::COORD_W'(cmd.y_end));
    w_s = signed'(bsor_pkg::COORD_W'(cmd.width));
    h_s = signed'(bsor_pkg::COORD_W'(cmd.height));

    x_right = xs + w_s - bsor_pkg::COORD_W'(1);
    y_bot   = ys + h_s - bsor_pkg::COORD_W'(1);

    dx  = sx - xs;
    dy  = sy - ys;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;

    sq_x   = adx[bsor_pkg::MAG_W-1:0] * adx[bsor_pkg::MAG_W-1:0];
    sq_y   = ady[bsor_pkg::MAG_W-1:0] * ady[bsor_pkg::MAG_W-1:0];
    sq_sum = bsor_pkg::SQ_W'(sq_x) + bsor_pkg::SQ_W'(sq_y);

    // A line that is neither horizontal nor vertical never matches.
    if (ys == ye) begin
      line_hit = (sy == ys) && (sx >= xs) && (sx <= xe);
    end else begin
      line_hit = (xs == xe) && (sx == xs) && (sy >= ys) && (sy <= ye);
    end

    in_x     = (sx >= xs) && (sx <= x_right);
    in_y     = (sy >= ys) && (sy <= y_bot);
    rect_hit = (cmd.width != '0) && (cmd.height != '0) &&
               ((in_x && ((sy == ys) || (sy == y_bot))) ||
                (in_y && ((sx == xs) || (sx == x_right))));

    // The two diagonals meet the base on its last row; the base fills between.
    tri_hit  = (dy >= 0) && (dy < h_s) &&
               ((adx == dy) || ((dy == h_s - bsor_pkg::COORD_W'(1)) && (adx <= dy)));

    ring_hit = (cmd.radius != '0) &&
               (sq_sum >= bsor_pkg::SQ_W'(cmd.ring_lo)) &&
               (sq_sum <= bsor_pkg::SQ_W'(cmd.ring_hi));

    unique case (cmd.func)
      bsor_pkg::FN_LINE: hit = line_hit;
      bsor_pkg::FN_RECT: hit = rect_hit;
      bsor_pkg::FN_TRI:  hit = tri_hit;
      bsor_pkg::FN_RING: hit = ring_hit;
      default:           hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_shape_outline_rasterizer.sv
// Top level of the bitmap shape outline rasterizer: command sequencer and frame.
// Depends on bsor_pkg, bsor_ram and bsor_hit.
`default_nettype none

// A command is taken when start is high and busy is low. Clear and unused codes
// give their result in the cycle after acceptance; a row read first passes
// through S_FETCH, which registers the row read from the frame as the result. A
// draw command sweeps the whole frame one pixel per cycle through the shared
// pixel test, with a fetch step (S_READ) before and a write-back step (S_WRITE)
// after each row, and busy stays high until the result. Every command returns
// one result, marked by out_valid for a single cycle; the receiver cannot stall
// it, so it must take it then. Draw commands return zero. The frame is cleared at
// reset and by a clear command via the row valid flags; no clearing pass is needed.
module bitmap_shape_outline_rasterizer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 in_func,
  input  wire logic [5:0]                 in_x_start,
  input  wire logic [4:0]                 in_y_start,
  input  wire logic [5:0]                 in_x_end,
  input  wire logic [4:0]                 in_y_end,
  input  wire logic [5:0]                 in_width,
  input  wire logic [4:0]                 in_height,
  input  wire logic [4:0]                 in_radius,
  output logic                            out_valid,
  output logic [bsor_pkg::OUT_W-1:0]      out_row_bits
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_READ,
    S_SWEEP,
    S_WRITE
  } state_t;

  state_t                           state_r;
  bsor_pkg::cmd_t                   cmd_r;
  logic [bsor_pkg::ROW_AW-1:0]      y_r;
  logic [bsor_pkg::COL_AW-1:0]      x_r;
  logic [bsor_pkg::FRAME_COLS-1:0]  mask_r, mask_nxt;
  logic [bsor_pkg::FRAME_ROWS-1:0]  valid_r;
  logic                             rd_hit_r;
  logic                             out_valid_r;
  logic [bsor_pkg::OUT_W-1:0]       out_row_bits_r;

  logic                             accept;
  logic                             read_in_range;
  logic [bsor_pkg::ROW_AW-1:0]      in_row;
  logic [bsor_pkg::RING_W-1:0]      r_sq;
  logic                             pix_hit;

  logic                             ram_rd_en, ram_wr_en;
  logic [bsor_pkg::ROW_AW-1:0]      ram_rd_addr;
  logic [bsor_pkg::FRAME_COLS-1:0]  ram_rd_data, old_row, wr_row_nxt;

  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign out_valid    = out_valid_r;
  assign out_row_bits = out_row_bits_r;

  assign in_row        = in_y_start[bsor_pkg::ROW_AW-1:0];
  assign read_in_range = (6'(in_y_start) < 6'(bsor_pkg::FRAME_ROWS));
  assign r_sq          = bsor_pkg::RING_W'(in_radius) * bsor_pkg::RING_W'(in_radius);

  assign ram_rd_en   = (accept && (in_func == bsor_pkg::FN_READ) && read_in_range) ||
                       (state_r == S_READ);
  assign ram_rd_addr = (state_r == S_IDLE) ? in_row : y_r;
  assign ram_wr_en   = (state_r == S_WRITE);

  // Rows never written since the last clear read as blank.
  assign old_row    = rd_hit_r ? ram_rd_data : '0;
  assign wr_row_nxt = old_row | mask_r;
  assign mask_nxt   = {pix_hit, mask_r[bsor_pkg::FRAME_COLS-1:1]};

  bsor_ram #(
    .WIDTH (bsor_pkg::FRAME_COLS),
    .DEPTH (bsor_pkg::FRAME_ROWS)
  ) u_frame (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (y_r),
    .wr_data (wr_row_nxt),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  bsor_hit u_hit (
    .cmd (cmd_r),
    .px  (x_r),
    .py  (y_r),
    .hit (pix_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      y_r         <= '0;
      x_r         <= '0;
      rd_hit_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r.func    <= in_func;
            cmd_r.x_start <= in_x_start;
            cmd_r.y_start <= in_y_start;
            cmd_r.x_end   <= in_x_end;
            cmd_r.y_end   <= in_y_end;
            cmd_r.width   <= in_width;
            cmd_r.height  <= in_height;
            cmd_r.radius  <= in_radius;
            cmd_r.ring_lo <= r_sq - bsor_pkg::RING_W'(in_radius);
            cmd_r.ring_hi <= r_sq + bsor_pkg::RING_W'(in_radius);
            y_r           <= '0;
            unique case (in_func)
              bsor_pkg::FN_LINE, bsor_pkg::FN_RECT,
              bsor_pkg::FN_TRI, bsor_pkg::FN_RING: begin
                out_valid_r <= 1'b0;
                state_r     <= S_READ;
              end
              bsor_pkg::FN_READ: begin
                out_valid_r <= 1'b0;
                rd_hit_r    <= read_in_range && valid_r[in_row];
                state_r     <= S_FETCH;
              end
              bsor_pkg::FN_CLEAR: begin
                valid_r        <= '0;
                out_valid_r    <= 1'b1;
                out_row_bits_r <= '0;
              end
              default: begin
                out_valid_r    <= 1'b1;
                out_row_bits_r <= '0;
              end
            endcase
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        S_FETCH: begin
          out_valid_r    <= 1'b1;
          out_row_bits_r <= bsor_pkg::row_to_out(old_row);
          state_r        <= S_IDLE;
        end
        S_READ: begin
          out_valid_r <= 1'b0;
          rd_hit_r    <= valid_r[y_r];
          x_r         <= '0;
          state_r     <= S_SWEEP;
        end
        S_SWEEP: begin
          out_valid_r <= 1'b0;
          mask_r      <= mask_nxt;
          x_r         <= x_r + 1'b1;
          if (x_r == bsor_pkg::COL_AW'(bsor_pkg::FRAME_COLS - 1)) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          valid_r[y_r] <= 1'b1;
          if (y_r == bsor_pkg::ROW_AW'(bsor_pkg::FRAME_ROWS - 1)) begin
            out_valid_r    <= 1'b1;
            out_row_bits_r <= '0;
            state_r        <= S_IDLE;
          end else begin
            out_valid_r <= 1'b0;
            y_r         <= y_r + 1'b1;
            state_r     <= S_READ;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only ever delivered once the sequencer is free again.
  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a command is still in progress");

  // A draw command keeps the block busy from the next cycle on.
  a_draw_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_func == bsor_pkg::FN_LINE) || (in_func == bsor_pkg::FN_RECT) ||
                (in_func == bsor_pkg::FN_TRI) || (in_func == bsor_pkg::FN_RING)))
    |=> (busy && !out_valid))
    else $error("draw command did not start the frame sweep");

  // Writing back the last row ends the sweep with a zero result.
  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WRITE) && (y_r == bsor_pkg::ROW_AW'(bsor_pkg::FRAME_ROWS - 1)))
    |=> (out_valid && (out_row_bits == '0) && !busy))
    else $error("frame sweep did not finish with a result");

  // A clear command blanks every row at once.
  a_clear_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == bsor_pkg::FN_CLEAR)) |=> (valid_r == '0) && out_valid)
    else $error("clear command left rows marked as written");

  // Row writes happen only in the write-back step of a sweep.
  a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (cmd_r.func != bsor_pkg::FN_READ) && (cmd_r.func != bsor_pkg::FN_CLEAR))
    else $error("frame row written outside a draw command");

endmodule

`default_nettype wire

// File: sim/bitmap_shape_outline_rasterizer_tb.sv
// Self-checking testbench for the bitmap shape outline rasterizer: directed command
// table, then random command traffic checked against a behavioral frame predictor.
// Depends on bsor_pkg and the bitmap_shape_outline_rasterizer top level.
module bitmap_shape_outline_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsor_pkg::*;

  localparam logic [2:0] FN_SPARE6   = 3'd6;
  localparam logic [2:0] FN_SPARE7   = 3'd7;
  localparam int         STALL_LIMIT = 5000;
  localparam int         N_DIRECTED  = 27;
  localparam int         N_RANDOM    = 750;
  localparam int         N_PHASES    = 4;

  typedef struct {
    logic [2:0]       func;
    logic [5:0]       xs;
    logic [4:0]       ys;
    logic [5:0]       xe;
    logic [4:0]       ye;
    logic [5:0]       w;
    logic [4:0]       h;
    logic [4:0]       r;
    bit               known;
    logic [OUT_W-1:0] golden;
  } cmd_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       in_func = '0;
  logic [5:0]       in_x_start = '0;
  logic [4:0]       in_y_start = '0;
  logic [5:0]       in_x_end = '0;
  logic [4:0]       in_y_end = '0;
  logic [5:0]       in_width = '0;
  logic [4:0]       in_height = '0;
  logic [4:0]       in_radius = '0;
  logic             out_valid;
  logic [OUT_W-1:0] out_row_bits;

  // Predicted frame contents, updated as each transaction is accepted.
  logic [FRAME_COLS-1:0] frame_img [FRAME_ROWS];
  logic [OUT_W-1:0]      pending_rows [$];

  bit               cur_known;
  logic [OUT_W-1:0] cur_golden;
  int               accept_count;
  int               result_count;
  int               stall_cycles;
  int               error_count;
  int               draw_count;
  int               read_count;
  int               lit_reads;

  cmd_row_t directed_rows [N_DIRECTED];
  int       phase_idle [N_PHASES] = '{0, 63, 0, 19};

  bitmap_shape_outline_rasterizer DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_x_start   (in_x_start),
    .in_y_start   (in_y_start),
    .in_x_end     (in_x_end),
    .in_y_end     (in_y_end),
    .in_width     (in_width),
    .in_height    (in_height),
    .in_radius    (in_radius),
    .out_valid    (out_valid),
    .out_row_bits (out_row_bits)
  );

  always #5 clk = ~clk;

  function automatic void plot(int x, int y);
    if (x >= 0 && y >= 0 && x < FRAME_COLS && y < FRAME_ROWS) begin
      frame_img[y][x] = 1'b1;
    end
  endfunction

  // Applies one command to the predicted frame and returns the row it reports.
  function automatic logic [OUT_W-1:0] apply_cmd(cmd_row_t c);
    logic [OUT_W-1:0] res;
    int xs, ys, xe, ye, w, h, r, i, x, y, d;
    xs = int'(c.xs);
    ys = int'(c.ys);
    xe = int'(c.xe);
    ye = int'(c.ye);
    w = int'(c.w);
    h = int'(c.h);
    r = int'(c.r);
    res = '0;
    case (c.func)
      FN_CLEAR: begin
        for (i = 0; i < FRAME_ROWS; i++) frame_img[i] = '0;
      end
      FN_LINE: begin
        if (ys == ye) begin
          for (i = xs; i <= xe; i++) plot(i, ys);
        end else if (xs == xe) begin
          for (i = ys; i <= ye; i++) plot(xs, i);
        end
      end
      FN_RECT: begin
        if (w != 0 && h != 0) begin
          for (i = xs; i < xs + w; i++) begin
            plot(i, ys);
            plot(i, ys + h - 1);
          end
          for (i = ys; i < ys + h; i++) begin
            plot(xs, i);
            plot(xs + w - 1, i);
          end
        end
      end
      FN_TRI: begin
        if (h != 0) begin
          for (i = 0; i < h; i++) begin
            plot(xs - i, ys + i);
            plot(xs + i, ys + i);
          end
          for (i = xs - h + 1; i <= xs + h - 1; i++) plot(i, ys + h - 1);
        end
      end
      FN_RING: begin
        if (r != 0) begin
          for (y = 0; y < FRAME_ROWS; y++) begin
            for (x = 0; x < FRAME_COLS; x++) begin
              d = (x - xs) * (x - xs) + (y - ys) * (y - ys);
              if (d >= r * r - r && d <= r * r + r) plot(x, y);
            end
          end
        end
      end
      FN_READ: begin
        if (ys < FRAME_ROWS) begin
          for (i = 0; i < OUT_W && i < FRAME_COLS; i++) res[i] = frame_img[ys][i];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly row reads and well-formed shapes near the frame, with a share of full-range fields.
  function automatic cmd_row_t make_random_cmd();
    cmd_row_t c;
    int pick, a, b;
    bit wild;
    c.xs = 6'($urandom);
    c.ys = 5'($urandom);
    c.xe = 6'($urandom);
    c.ye = 5'($urandom);
    c.w = 6'($urandom);
    c.h = 5'($urandom);
    c.r = 5'($urandom);
    c.known = 1'b0;
    c.golden = '0;
    wild = ($urandom_range(7) == 0);
    pick = $urandom_range(99);
    if (pick < 3) begin
      c.func = FN_CLEAR;
    end else if (pick < 18) begin
      c.func = FN_LINE;
      pick = $urandom_range(9);
      if (pick < 4 || pick == 9) begin
        a = $urandom_range(FRAME_COLS + 3);
        b = $urandom_range(FRAME_COLS + 3);
        c.ye = c.ys;
        c.xs = 6'((a < b) == (pick != 9) ? a : b);
        c.xe = 6'((a < b) == (pick != 9) ? b : a);
      end else if (pick < 8) begin
        a = $urandom_range(FRAME_ROWS + 3);
        b = $urandom_range(FRAME_ROWS + 3);
        c.xe = c.xs;
        c.ys = 5'(a < b ? a : b);
        c.ye = 5'(a < b ? b : a);
      end
    end else if (pick < 30) begin
      c.func = FN_RECT;
      if (!wild) begin
        c.xs = 6'($urandom_range(FRAME_COLS - 1));
        c.ys = 5'($urandom_range(FRAME_ROWS - 1));
        c.w = 6'($urandom_range(FRAME_COLS));
        c.h = 5'($urandom_range(FRAME_ROWS));
      end
    end else if (pick < 40) begin
      c.func = FN_TRI;
      if (!wild) begin
        c.xs = 6'($urandom_range(FRAME_COLS + 5));
        c.ys = 5'($urandom_range(FRAME_ROWS - 1));
        c.h = 5'($urandom_range(FRAME_ROWS));
      end
    end else if (pick < 48) begin
      c.func = FN_RING;
      if (!wild) begin
        c.xs = 6'($urandom_range(FRAME_COLS + 5));
        c.ys = 5'($urandom_range(FRAME_ROWS + 2));
        c.r = 5'($urandom_range(12));
      end
    end else if (pick < 96) begin
      c.func = FN_READ;
      if ($urandom_range(9) != 0) c.ys = 5'($urandom_range(FRAME_ROWS - 1));
    end else begin
      c.func = $urandom_range(1) ? FN_SPARE7 : FN_SPARE6;
    end
    return c;
  endfunction

  // Presents one command after an optional idle gap and holds it until accepted.
  task automatic send_cmd(input cmd_row_t c, input int idle_pct);
    int seen;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    cur_known = c.known;
    cur_golden = c.golden;
    in_func <= c.func;
    in_x_start <= c.xs;
    in_y_start <= c.ys;
    in_x_end <= c.xe;
    in_y_end <= c.ye;
    in_width <= c.w;
    in_height <= c.h;
    in_radius <= c.r;
    start <= 1'b1;
    seen = accept_count;
    do @(negedge clk); while (accept_count == seen);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_rows.size() != 0) @(negedge clk);
  endtask

  // Checks results against the oldest expectation, then records accepted commands.
  always @(posedge clk) begin : monitor
    logic [OUT_W-1:0] want;
    cmd_row_t         c;
    bit               moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        moved = 1'b1;
        result_count++;
        if (out_row_bits != '0) lit_reads++;
        if (pending_rows.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result, row_bits %h", out_row_bits);
        end else begin
          want = pending_rows.pop_front();
          if (out_row_bits !== want) begin
            error_count++;
            if (error_count <= 10) begin
              $display("row_bits mismatch on result %0d: expected %h, got %h",
                       result_count, want, out_row_bits);
            end
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        c.func = in_func;
        c.xs = in_x_start;
        c.ys = in_y_start;
        c.xe = in_x_end;
        c.ye = in_y_end;
        c.w = in_width;
        c.h = in_height;
        c.r = in_radius;
        want = apply_cmd(c);
        pending_rows.push_back(cur_known ? cur_golden : want);
        if (in_func == FN_READ) read_count++;
        if (in_func inside {FN_LINE, FN_RECT, FN_TRI, FN_RING}) draw_count++;
        accept_count++;
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("bitmap_shape_outline_rasterizer_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int ph, n;
    for (n = 0; n < FRAME_ROWS; n++) frame_img[n] = '0;
    directed_rows = '{
      '{FN_READ,   6'd0,  5'd0,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_LINE,   6'd0,  5'd0,  6'd63, 5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_READ,   6'd0,  5'd0,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'hFF_FFFF_FFFF},
      '{FN_CLEAR,  6'd63, 5'd31, 6'd63, 5'd31, 6'd63, 5'd31, 5'd31, 1'b1, 40'h0},
      '{FN_READ,   6'd0,  5'd0,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_LINE,   6'd39, 5'd0,  6'd39, 5'd31, 6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_READ,   6'd0,  5'd19, 6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h80_0000_0000},
      '{FN_READ,   6'd0,  5'd31, 6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_LINE,   6'd1,  5'd1,  6'd5,  5'd5,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_LINE,   6'd10, 5'd3,  6'd5,  5'd3,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_READ,   6'd0,  5'd3,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b0, 40'h0},
      '{FN_RECT,   6'd0,  5'd0,  6'd0,  5'd0,  6'd40, 5'd20, 5'd0,  1'b1, 40'h0},
      '{FN_RECT,   6'd5,  5'd5,  6'd0,  5'd0,  6'd0,  5'd5,  5'd0,  1'b1, 40'h0},
      '{FN_RECT,   6'd5,  5'd5,  6'd0,  5'd0,  6'd5,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_RECT,   6'd63, 5'd31, 6'd0,  5'd0,  6'd63, 5'd31, 5'd0,  1'b1, 40'h0},
      '{FN_READ,   6'd0,  5'd10, 6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b0, 40'h0},
      '{FN_TRI,    6'd20, 5'd2,  6'd0,  5'd0,  6'd0,  5'd20, 5'd0,  1'b1, 40'h0},
      '{FN_TRI,    6'd10, 5'd10, 6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_TRI,    6'd0,  5'd0,  6'd0,  5'd0,  6'd0,  5'd1,  5'd0,  1'b1, 40'h0},
      '{FN_READ,   6'd0,  5'd19, 6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b0, 40'h0},
      '{FN_CLEAR,  6'd0,  5'd0,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_RING,   6'd20, 5'd10, 6'd0,  5'd0,  6'd0,  5'd0,  5'd10, 1'b1, 40'h0},
      '{FN_RING,   6'd5,  5'd5,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0},
      '{FN_RING,   6'd0,  5'd0,  6'd0,  5'd0,  6'd0,  5'd0,  5'd31, 1'b1, 40'h0},
      '{FN_READ,   6'd0,  5'd9,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b0, 40'h0},
      '{FN_SPARE6, 6'd63, 5'd31, 6'd63, 5'd31, 6'd63, 5'd31, 5'd31, 1'b1, 40'h0},
      '{FN_SPARE7, 6'd0,  5'd0,  6'd0,  5'd0,  6'd0,  5'd0,  5'd0,  1'b1, 40'h0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_cmd(directed_rows[i], 0);
    drain_results();

    // The random traffic runs in phases with sender idle rates of 0, 63, 0 and 19
    // percent, and the sender waits for every outstanding result between phases.
    for (ph = 0; ph < N_PHASES; ph++) begin
      for (n = 0; n < N_RANDOM / N_PHASES; n++) send_cmd(make_random_cmd(), phase_idle[ph]);
      drain_results();
    end

    repeat (20) @(negedge clk);
    $display("Ran %0d commands: %0d draws and %0d row reads, %0d results non-zero.",
             accept_count, draw_count, read_count, lit_reads);
    $display("Checked %0d results with sender idle rates of 0, 19 and 63 percent.",
             result_count);
    if (error_count == 0 && pending_rows.size() == 0) begin
      $display("bitmap_shape_outline_rasterizer_tb: done, clean");
    end else begin
      $display("bitmap_shape_outline_rasterizer_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: bitmap_shape_outline_rasterizer.f
hw/rtl/bsor_pkg.sv
hw/rtl/bsor_ram.sv
hw/rtl/bsor_hit.sv
hw/rtl/bitmap_shape_outline_rasterizer.sv
sim/bitmap_shape_outline_rasterizer_tb.sv
